// ----- rtl/dbr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the table-file to tab-separated text converter.
// Depends on nothing; every other file of the block but dbr_ram imports it.
package dbr_pkg;

  localparam int NAME_CHARS  = 10;
  localparam int TAB_W       = 11;  // holds any field count a 16-bit header length allows
  localparam int MAX_OUT     = 12;  // runs per input byte
  localparam int QUEUE_DEPTH = 4;
  localparam int NSLOT       = 16;

  // field kinds kept in the descriptor store
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_OTHER = 2'd0;
  localparam kind_t KIND_NUM   = 2'd1;
  localparam kind_t KIND_MEMO  = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_N     = 8'h4E;

  // emit slots of one queue entry, in output order
  localparam logic [3:0] SLOT_ERR     = 4'd0;
  localparam logic [3:0] SLOT_TAB_PRE = 4'd1;
  localparam logic [3:0] SLOT_NAME    = 4'd2;
  localparam logic [3:0] SLOT_SPACES  = 4'd12;
  localparam logic [3:0] SLOT_CHR     = 4'd13;
  localparam logic [3:0] SLOT_TABS    = 4'd14;
  localparam logic [3:0] SLOT_NL      = 4'd15;

  // everything one input byte makes the back end emit
  typedef struct packed {
    logic                             err;
    logic                             tab_pre;
    logic [NAME_CHARS-1:0][7:0]       name;
    logic [3:0]                       name_len;
    logic [7:0]                       spaces;
    logic                             chr_ok;
    logic [7:0]                       chr;
    logic [TAB_W-1:0]                 tabs;
    logic                             nl;
  } dbr_entry_t;

  function automatic kind_t kind_of(input logic [7:0] b);
    kind_t k;
    k = KIND_OTHER;
    if (b == CH_M) k = KIND_MEMO;
    else if (b == CH_N) k = KIND_NUM;
    return k;
  endfunction

  // index of the first NUL, or NAME_CHARS when there is none
  function automatic logic [3:0] name_length(input logic [NAME_CHARS-1:0][7:0] name);
    logic [3:0] n;
    n = 4'(NAME_CHARS);
    for (int k = NAME_CHARS - 1; k >= 0; k--) begin
      if (name[k] == CH_NUL) n = 4'(k);
    end
    return n;
  endfunction

  // one bit per slot that has something to emit
  function automatic logic [NSLOT-1:0] slot_mask(input dbr_entry_t e);
    logic [NSLOT-1:0] m;
    m = '0;
    m[SLOT_ERR]     = e.err;
    m[SLOT_TAB_PRE] = e.tab_pre;
    for (int k = 0; k < NAME_CHARS; k++) begin
      m[int'(SLOT_NAME) + k] = (4'(k) < e.name_len);
    end
    m[SLOT_SPACES] = (e.spaces != '0);
    m[SLOT_CHR]    = e.chr_ok;
    m[SLOT_TABS]   = (e.tabs != '0);
    m[SLOT_NL]     = e.nl;
    return m;
  endfunction

endpackage

// ----- rtl/dbr_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/dbr_front.sv -----
`timescale 1ns / 1ps
// Front end: parses header, descriptors and records, one byte per transfer, into queue entries.
// Depends on dbr_pkg and dbr_ram (descriptor stores, two read ports each).
module dbr_front #(
  parameter int MAX_FIELDS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  logic [7:0]          data_byte,
  input  logic                end_of_file,
  input  logic                q_full,
  output logic                push,
  output dbr_pkg::dbr_entry_t push_data
);
  import dbr_pkg::*;

  localparam int AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int FW = $clog2(MAX_FIELDS + 1);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DESC   = 4'b0010,
    PH_RECORD = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  phase_t                     phase, phase_next;
  logic [15:0]                pos, pos_next;
  logic [15:0]                hlen, hlen_next;
  logic [15:0]                rlen, rlen_next;
  logic [31:0]                rec_exp, rec_exp_next;
  logic [31:0]                rec_seen, rec_seen_next;
  logic [TAB_W-1:0]           ftot, ftot_next;
  logic [NAME_CHARS-1:0][7:0] name_buf, name_next;
  logic [FW-1:0]              cf, cf_next;
  logic [7:0]                 off, off_next;
  logic                       del, del_next;
  logic                       nul, nul_next;
  logic                       started, started_next;
  logic [7:0]                 spaces, spaces_next;
  logic                       closing, closing_next;
  logic                       cl_last, cl_last_next;
  logic                       cl_eof, cl_eof_next;
  dbr_entry_t                 held, held_next;

  dbr_entry_t       ent;
  logic             acc, do_reset, start_rec, last_rec, close_c, more, del_c;
  logic [FW-1:0]    cf_c;
  logic [TAB_W-1:0] cf1, ft, di;
  logic [15:0]      rel;
  logic [4:0]       doff;
  logic             kind_we, len_we;
  kind_t            wr_kind;
  kind_t            k0, k1;
  logic [7:0]       l0, l1;
  logic [AW-1:0]    ra, rb, wa;

  assign acc        = data_valid && !data_stall;
  assign data_stall = closing || q_full;
  assign push_data  = ent;

  // descriptor stores: port a reads the current field, port b the one after it
  assign ra  = cf_next[AW-1:0];
  assign rb  = AW'(cf_next + 1'b1);
  assign rel = pos - 16'd32;
  assign di  = rel[15:5];
  assign doff = rel[4:0];
  assign wa  = di[AW-1:0];

  dbr_ram #(.WIDTH(2), .DEPTH(MAX_FIELDS)) u_kind_a (
    .clk(clk), .wr_en(kind_we), .wr_addr(wa), .wr_data(wr_kind), .rd_addr(ra), .rd_data(k0));
  dbr_ram #(.WIDTH(2), .DEPTH(MAX_FIELDS)) u_kind_b (
    .clk(clk), .wr_en(kind_we), .wr_addr(wa), .wr_data(wr_kind), .rd_addr(rb), .rd_data(k1));
  dbr_ram #(.WIDTH(8), .DEPTH(MAX_FIELDS)) u_len_a (
    .clk(clk), .wr_en(len_we), .wr_addr(wa), .wr_data(data_byte), .rd_addr(ra), .rd_data(l0));
  dbr_ram #(.WIDTH(8), .DEPTH(MAX_FIELDS)) u_len_b (
    .clk(clk), .wr_en(len_we), .wr_addr(wa), .wr_data(data_byte), .rd_addr(rb), .rd_data(l1));

  // parser next state
  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    hlen_next     = hlen;
    rlen_next     = rlen;
    rec_exp_next  = rec_exp;
    rec_seen_next = rec_seen;
    ftot_next     = ftot;
    name_next     = name_buf;
    cf_next       = cf;
    off_next      = off;
    del_next      = del;
    nul_next      = nul;
    started_next  = started;
    spaces_next   = spaces;
    closing_next  = closing;
    cl_last_next  = cl_last;
    cl_eof_next   = cl_eof;
    held_next     = held;
    ent           = '0;
    push          = 1'b0;
    kind_we       = 1'b0;
    len_we        = 1'b0;
    wr_kind       = kind_of(data_byte);
    do_reset      = 1'b0;
    start_rec     = 1'b0;
    close_c       = 1'b0;
    more          = 1'b0;
    cf_c          = cf;
    del_c         = del;
    cf1           = '0;
    ft            = '0;
    last_rec      = (17'(pos) + 17'd1 >= 17'(rlen));

    if (closing) begin
      // close one field per cycle, the last one only while the queue is not full, counting tabs for the fields entered
      cf1  = TAB_W'(cf) + 1'b1;
      more = (cf1 < ftot) && (cl_last || l1 == 8'd0);
      if (more || !q_full) begin
        ent = held;
        if (cf1 < ftot && !del && k1 != KIND_MEMO) ent.tabs = held.tabs + 1'b1;
        cf_next   = FW'(cf1);
        held_next = ent;
        if (!more) begin
          ent.nl       = cl_last && !del;
          push         = (slot_mask(ent) != '0);
          closing_next = 1'b0;
          if (cl_last) cf_next = '0;
          do_reset     = cl_eof;
        end
      end
    end else if (acc) begin
      unique case (phase)
        PH_HEADER: begin
          if (pos >= 16'd4 && pos <= 16'd7) rec_exp_next[{pos[1:0], 3'b000} +: 8] = data_byte;
          if (pos == 16'd8)  hlen_next[7:0]  = data_byte;
          if (pos == 16'd9)  hlen_next[15:8] = data_byte;
          if (pos == 16'd10) rlen_next[7:0]  = data_byte;
          if (pos == 16'd11) rlen_next[15:8] = data_byte;
          pos_next = pos + 16'd1;
          if (pos == 16'd31) begin
            ft        = (hlen >= 16'd32) ? (hlen[15:5] - 11'd1) : '0;
            ftot_next = ft;
            if (ft > TAB_W'(MAX_FIELDS)) begin
              ent.err    = 1'b1;
              phase_next = PH_IDLE;
            end else if (hlen <= 16'd32) begin
              ent.nl    = 1'b1;
              start_rec = 1'b1;
            end else begin
              phase_next = PH_DESC;
            end
          end
          push = (slot_mask(ent) != '0);
        end
        PH_DESC: begin
          if (di < ftot) begin
            if (doff < 5'd10) begin
              name_next[doff[3:0]] = data_byte;
            end else if (doff == 5'd11) begin
              kind_we = 1'b1;
              if (wr_kind != KIND_MEMO) begin
                ent.tab_pre  = (di != '0);
                ent.name     = name_buf;
                ent.name_len = name_length(name_buf);
              end
            end else if (doff == 5'd16) begin
              len_we = 1'b1;
            end
          end
          if (17'(pos) + 17'd1 >= 17'(hlen)) begin
            ent.nl    = 1'b1;
            start_rec = 1'b1;
          end else begin
            pos_next = pos + 16'd1;
          end
          push = (slot_mask(ent) != '0);
        end
        PH_RECORD: begin
          if (pos == 16'd0) begin
            // first byte: deletion mark; field 0 is already on port a
            del_c        = (data_byte == CH_STAR);
            cf_c         = '0;
            off_next     = '0;
            nul_next     = 1'b0;
            started_next = 1'b0;
            spaces_next  = '0;
            close_c      = (ftot != '0) && (l0 == 8'd0 || last_rec);
          end else if (TAB_W'(cf) < ftot) begin
            if (!del && k0 != KIND_MEMO && !nul) begin
              if (data_byte == CH_NUL) begin
                nul_next = 1'b1;
              end else if (data_byte == CH_SPACE) begin
                if (!(k0 == KIND_NUM && !started))
                  spaces_next = (spaces == 8'hFF) ? spaces : spaces + 8'd1;
              end else begin
                ent.spaces   = spaces;
                ent.chr_ok   = 1'b1;
                ent.chr      = data_byte;
                spaces_next  = '0;
                started_next = 1'b1;
              end
            end
            off_next = off + 8'd1;
            close_c  = (9'(off) + 9'd1 >= 9'(l0)) || last_rec;
          end
          del_next = del_c;
          if (close_c) begin
            cf1          = TAB_W'(cf_c) + 1'b1;
            cf_next      = FW'(cf1);
            off_next     = '0;
            nul_next     = 1'b0;
            started_next = 1'b0;
            spaces_next  = '0;
            if (cf1 < ftot && !del_c && k1 != KIND_MEMO) ent.tabs = TAB_W'(1);
            more = (cf1 < ftot) && (last_rec || l1 == 8'd0);
          end
          if (more) begin
            closing_next = 1'b1;
            held_next    = ent;
            cl_last_next = last_rec;
            cl_eof_next  = end_of_file;
          end else begin
            if (last_rec) begin
              ent.nl  = !del_c;
              cf_next = '0;
            end
            push = (slot_mask(ent) != '0);
          end
          if (last_rec) begin
            rec_seen_next = rec_seen + 32'd1;
            pos_next      = '0;
            if (rec_seen + 32'd1 == rec_exp) phase_next = PH_IDLE;
          end else begin
            pos_next = pos + 16'd1;
          end
        end
        PH_IDLE: ;
        default: ;
      endcase
      if (end_of_file && !closing_next) do_reset = 1'b1;
    end

    if (start_rec) begin
      pos_next      = '0;
      rec_seen_next = '0;
      cf_next       = '0;
      phase_next    = (rec_exp == 32'd0 || rlen == 16'd0) ? PH_IDLE : PH_RECORD;
    end

    // end of file: back to header parsing
    if (do_reset) begin
      phase_next    = PH_HEADER;
      pos_next      = '0;
      hlen_next     = '0;
      rlen_next     = '0;
      rec_exp_next  = '0;
      rec_seen_next = '0;
      ftot_next     = '0;
      cf_next       = '0;
      off_next      = '0;
      del_next      = 1'b0;
      nul_next      = 1'b0;
      started_next  = 1'b0;
      spaces_next   = '0;
      closing_next  = 1'b0;
      cl_eof_next   = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      pos      <= '0;
      hlen     <= '0;
      rlen     <= '0;
      rec_exp  <= '0;
      rec_seen <= '0;
      ftot     <= '0;
      cf       <= '0;
      off      <= '0;
      del      <= 1'b0;
      nul      <= 1'b0;
      started  <= 1'b0;
      spaces   <= '0;
      closing  <= 1'b0;
      cl_last  <= 1'b0;
      cl_eof   <= 1'b0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      hlen     <= hlen_next;
      rlen     <= rlen_next;
      rec_exp  <= rec_exp_next;
      rec_seen <= rec_seen_next;
      ftot     <= ftot_next;
      cf       <= cf_next;
      off      <= off_next;
      del      <= del_next;
      nul      <= nul_next;
      started  <= started_next;
      spaces   <= spaces_next;
      closing  <= closing_next;
      cl_last  <= cl_last_next;
      cl_eof   <= cl_eof_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    name_buf <= name_next;
    held     <= held_next;
  end

endmodule

// ----- rtl/dbr_queue.sv -----
`timescale 1ns / 1ps
// Short entry queue between front and back end.
// Depends on dbr_pkg.
module dbr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dbr_pkg::dbr_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output dbr_pkg::dbr_entry_t head
);
  import dbr_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  dbr_entry_t    mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full       = (count == (PW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ----- rtl/dbr_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the emit slots of each queue entry and merges them into output runs.
// Depends on dbr_pkg.
module dbr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  dbr_pkg::dbr_entry_t head,
  output logic                pop,
  output logic                text_valid,
  input  logic                text_stall,
  output logic [7:0]          text_byte,
  output logic [7:0]          repeat_count,
  output logic                format_error,
  output logic                last_in_run
);
  import dbr_pkg::*;

  // run under construction
  logic             cur_v, ncur_v;
  logic [7:0]       cur_byte, ncur_byte;
  logic [7:0]       cur_cnt, ncur_cnt;
  logic             cur_err, ncur_err;
  logic [3:0]       nruns, nruns_n;
  logic             loaded;
  logic [NSLOT-1:0] pend, pend_eff, pend_after;
  logic             rem_live;
  logic [TAB_W-1:0] rem, r, r_after, take, full_cnt;
  logic [3:0]       s, name_idx;
  logic [7:0]       sb, room;
  logic             emit_old, finish, need_out, go, out_free;

  assign out_free = !text_valid || !text_stall;
  assign pend_eff = loaded ? pend : slot_mask(head);
  assign name_idx = s - SLOT_NAME;
  assign room     = 8'hFF - cur_cnt;

  // lowest pending slot
  always_comb begin
    s = '0;
    for (int k = NSLOT - 1; k >= 0; k--) begin
      if (pend_eff[k]) s = 4'(k);
    end
  end

  // byte and count of that slot
  always_comb begin
    full_cnt = TAB_W'(1);
    if (s == SLOT_ERR) sb = CH_NUL;
    else if (s == SLOT_TAB_PRE || s == SLOT_TABS) sb = CH_TAB;
    else if (s == SLOT_SPACES) sb = CH_SPACE;
    else if (s == SLOT_CHR) sb = head.chr;
    else if (s == SLOT_NL) sb = CH_NL;
    else sb = (name_idx < 4'(NAME_CHARS)) ? head.name[name_idx] : CH_NUL;
    if (s == SLOT_SPACES) full_cnt = TAB_W'(head.spaces);
    else if (s == SLOT_TABS) full_cnt = head.tabs;
    r = rem_live ? rem : full_cnt;
  end

  // merge, split or drop the slot's bytes
  always_comb begin
    ncur_v    = cur_v;
    ncur_byte = cur_byte;
    ncur_cnt  = cur_cnt;
    ncur_err  = cur_err;
    nruns_n   = nruns;
    emit_old  = 1'b0;
    take      = '0;
    if (pend_eff != '0) begin
      if (cur_v && !cur_err && cur_byte == sb && cur_cnt != 8'hFF && s != SLOT_ERR) begin
        take     = (r < TAB_W'(room)) ? r : TAB_W'(room);
        ncur_cnt = cur_cnt + 8'(take);
      end else if (nruns >= 4'(MAX_OUT)) begin
        take = r;
      end else begin
        emit_old  = cur_v;
        take      = (r > TAB_W'(255)) ? TAB_W'(255) : r;
        ncur_v    = 1'b1;
        ncur_byte = sb;
        ncur_cnt  = 8'(take);
        ncur_err  = (s == SLOT_ERR);
        nruns_n   = nruns + 4'd1;
      end
    end
    r_after    = r - take;
    pend_after = (r_after == '0) ? (pend_eff & ~(NSLOT'(1) << s)) : pend_eff;
    finish     = (pend_after == '0) && !emit_old;
    need_out   = emit_old || (finish && ncur_v);
    go         = head_valid && (!need_out || out_free);
    pop        = go && finish;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
      cur_v      <= 1'b0;
      nruns      <= '0;
      loaded     <= 1'b0;
      rem_live   <= 1'b0;
    end else begin
      if (out_free) text_valid <= 1'b0;
      if (go) begin
        if (emit_old || (finish && ncur_v)) text_valid <= 1'b1;
        if (finish) begin
          cur_v    <= 1'b0;
          nruns    <= '0;
          loaded   <= 1'b0;
          rem_live <= 1'b0;
        end else begin
          cur_v    <= ncur_v;
          nruns    <= nruns_n;
          loaded   <= 1'b1;
          rem_live <= (r_after != '0);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (go) begin
      if (emit_old) begin
        text_byte    <= cur_byte;
        repeat_count <= cur_cnt;
        format_error <= cur_err;
        last_in_run  <= 1'b0;
      end else if (finish && ncur_v) begin
        text_byte    <= ncur_byte;
        repeat_count <= ncur_cnt;
        format_error <= ncur_err;
        last_in_run  <= 1'b1;
      end
      if (!finish) begin
        cur_byte <= ncur_byte;
        cur_cnt  <= ncur_cnt;
        cur_err  <= ncur_err;
        pend     <= pend_after;
        rem      <= r_after;
      end
    end
  end

  // checks
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> repeat_count != 8'd0)
    else $error("empty run issued");
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    (text_valid && format_error) |-> (last_in_run && text_byte == CH_NUL && repeat_count == 8'd1))
    else $error("error result malformed");
  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    nruns <= 4'(MAX_OUT))
    else $error("too many runs for one byte");

endmodule

// ----- rtl/dbf_record_to_tsv.sv -----
`timescale 1ns / 1ps
// Table file to tab-separated text converter. One byte of the file enters per cycle while
// data_stall is low; the input is held while the queue is full and while a record byte that
// closes several fields at once (zero-length fields, or the fields still open at a record's
// last byte) closes the extra fields one by one, one descriptor-store read each. Output is
// given as runs of a repeated byte. The back end handles the emit slots of a queue entry
// one at a time (a tab, each name character, the held spaces, the text character, the
// closing tabs, the newline), splits a run each time it reaches 255, and issues a new run
// that an entry's last slot opens only after the earlier run. A four-entry queue decouples the two sides.
// Depends on dbr_pkg, dbr_front, dbr_queue, dbr_back.
module dbf_record_to_tsv #(
  parameter int MAX_FIELDS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       text_valid,
  input  logic       text_stall,
  output logic [7:0] text_byte,
  output logic [7:0] repeat_count,
  output logic       format_error,
  output logic       last_in_run
);
  import dbr_pkg::*;

  dbr_entry_t push_data, head;
  logic       push, q_full, pop, head_valid;

  dbr_front #(.MAX_FIELDS(MAX_FIELDS)) u_front (
    .clk(clk), .rst(rst), .data_valid(data_valid), .data_stall(data_stall),
    .data_byte(data_byte), .end_of_file(end_of_file), .q_full(q_full),
    .push(push), .push_data(push_data));

  dbr_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .head_valid(head_valid), .head(head));

  dbr_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .text_valid(text_valid), .text_stall(text_stall), .text_byte(text_byte),
    .repeat_count(repeat_count), .format_error(format_error), .last_in_run(last_in_run));

endmodule
